// ===== sv/cpu_load_window_meter_core_defines.svh =====
// Assertion macros shared by the load meter RTL.
`ifndef CPU_LOAD_WINDOW_METER_CORE_DEFINES_SVH
`define CPU_LOAD_WINDOW_METER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clk edge outside reset.
`define CLWM_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("clwm same-cycle check failed");

// Next-cycle implication.
`define CLWM_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("clwm next-cycle check failed");

`endif

// ===== sv/clwm_pkg.sv =====
// ----------------------------------------------------------------------------
// clwm_pkg
// Types and constants of the CPU load window meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clwm_pkg;

  localparam int CNT_BITS   = 32;
  localparam int TENTHS_W   = 10;
  localparam int THOU_W     = 17;
  localparam int PCT_W      = 7;
  localparam int SCALE_W    = 17;
  localparam int PROD_W     = CNT_BITS + SCALE_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int STEP_CNT_W = $clog2(NUM_W);

  localparam logic [CNT_BITS-1:0] WINDOW_RESET = 32'd1000000;
  localparam logic [SCALE_W-1:0]  SCALE_TENTHS = 17'd1000;
  localparam logic [SCALE_W-1:0]  SCALE_THOU   = 17'd100000;

  // (x + 5) / 10 as (x + 5) * 205 >> 11, exact below 1029
  localparam int             PCT_ROUND = 5;
  localparam logic [7:0]     PCT_RECIP = 8'd205;
  localparam int             PCT_SHIFT = 11;
  localparam int             PCT_SUM_W = TENTHS_W + 1;
  localparam int             PCT_MUL_W = PCT_SUM_W + 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_CHECK,
    ST_PREP,
    ST_DIV_T,
    ST_DIV_K,
    ST_DONE
  } clwm_state_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_ADD,
    DV_STEP,
    DV_DONE
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== sv/clwm_divider.sv =====
// ----------------------------------------------------------------------------
// clwm_divider
// Rounded share unit: (dividend * scale + divisor / 2) / divisor, one
// quotient bit per cycle. Caller guarantees dividend < divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clwm_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [clwm_pkg::CNT_BITS-1:0]  dividend,
  input  wire logic [clwm_pkg::CNT_BITS-1:0]  divisor,
  input  wire logic [clwm_pkg::SCALE_W-1:0]   scale,
  output logic      [clwm_pkg::SCALE_W-1:0]   quotient,
  output clwm_pkg::div_stat_t                 stat
);
  import clwm_pkg::*;

  div_state_t state, state_next;

  logic [PROD_W-1:0]     product;
  logic [NUM_W-1:0]      num;
  logic [CNT_BITS-1:0]   rem;
  logic [STEP_CNT_W-1:0] count;
  logic [CNT_BITS:0]     trial;
  logic                  fits;

  assign trial = {rem, num[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    state_next = state;
    unique case (state)
      DV_IDLE: if (start) state_next = DV_MUL;
      DV_MUL:  state_next = DV_ADD;
      DV_ADD:  state_next = DV_STEP;
      DV_STEP: if (count == '0) state_next = DV_DONE;
      DV_DONE: state_next = start ? DV_MUL : DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state != DV_IDLE) && (state != DV_DONE);
    stat.done = (state == DV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DV_MUL: begin
        product <= PROD_W'(dividend * scale);
      end
      DV_ADD: begin
        // add half the divisor for round-to-nearest
        num      <= NUM_W'(product) + NUM_W'(divisor >> 1);
        rem      <= '0;
        quotient <= '0;
        count    <= STEP_CNT_W'(NUM_W - 1);
      end
      DV_STEP: begin
        num      <= num << 1;
        count    <= count - 1'b1;
        quotient <= {quotient[SCALE_W-2:0], fits};
        if (fits) begin
          rem <= CNT_BITS'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[CNT_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/cpu_load_window_meter_core.sv =====
// ----------------------------------------------------------------------------
// cpu_load_window_meter_core
// Measures busy share per window from event stamps and the idle flag.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    time_stamp, idle_now
// out       source     out_valid / out_ready  load_tenths, load_thousandths,
//                                             load_percent, window_closed
// cfg       sink       cfg_wr_en              cfg_wr_data
//
// An event that closes no window passes the accumulate and check states to
// the output register; the first event after reset goes straight to done.
// A window that is empty or saturates skips the divider; any other closed
// window runs the two 50-step restoring divisions of the shared divider.
// Reset clears the counters, the stored loads and the handshake state.
// A result waits in the output register; in_ready returns while it waits,
// and a following result holds in the done state until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cpu_load_window_meter_core_defines.svh"

module cpu_load_window_meter_core #(
  parameter int STAMP_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [clwm_pkg::CNT_BITS-1:0]   cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [STAMP_BITS-1:0]           time_stamp,
  input  wire logic                            idle_now,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [clwm_pkg::TENTHS_W-1:0]   load_tenths,
  output logic      [clwm_pkg::THOU_W-1:0]     load_thousandths,
  output logic      [clwm_pkg::PCT_W-1:0]      load_percent,
  output logic                                 window_closed
);
  import clwm_pkg::*;

  clwm_state_t state, state_next;

  logic [CNT_BITS-1:0]   window_length_clocks;
  logic [CNT_BITS-1:0]   window_count;
  logic [CNT_BITS-1:0]   idle_count;
  logic [STAMP_BITS-1:0] last_stamp;
  logic                  last_was_idle;
  logic                  stamp_seen;
  logic [TENTHS_W-1:0]   stored_tenths;
  logic [THOU_W-1:0]     stored_thousandths;

  logic [CNT_BITS-1:0]   elapsed;
  logic                  add_idle;
  logic                  closed;
  logic [CNT_BITS-1:0]   busy_clocks;
  logic [CNT_BITS-1:0]   win_clocks;

  logic [STAMP_BITS-1:0] stamp_diff;
  logic                  in_beat;
  logic                  out_free;
  logic                  window_full;
  logic                  div_start;
  logic [SCALE_W-1:0]    div_scale;
  logic [SCALE_W-1:0]    div_quotient;
  div_stat_t             div_stat;
  logic [PCT_MUL_W-1:0]  pct_product;

  assign stamp_diff  = time_stamp - last_stamp;
  assign in_beat     = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign window_full = window_count >= window_length_clocks;
  assign pct_product = PCT_MUL_W'(PCT_SUM_W'(stored_tenths) + PCT_SUM_W'(PCT_ROUND))
                       * PCT_MUL_W'(PCT_RECIP);

  clwm_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (busy_clocks),
    .divisor  (win_clocks),
    .scale    (div_scale),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_beat) state_next = stamp_seen ? ST_ACCUM : ST_DONE;
      end
      ST_ACCUM: state_next = ST_CHECK;
      ST_CHECK: state_next = window_full ? ST_PREP : ST_DONE;
      ST_PREP: begin
        if (win_clocks == '0 || busy_clocks >= win_clocks) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_DIV_T;
        end
      end
      ST_DIV_T: if (div_stat.done) state_next = ST_DIV_K;
      ST_DIV_K: if (div_stat.done) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = (state == ST_IDLE);
    div_start = 1'b0;
    div_scale = (state == ST_DIV_K) ? SCALE_THOU : SCALE_TENTHS;
    unique case (state)
      ST_PREP:  div_start = (win_clocks != '0) && (busy_clocks < win_clocks);
      ST_DIV_T: div_start = div_stat.done;
      default:  div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      window_length_clocks <= WINDOW_RESET;
      window_count         <= '0;
      idle_count           <= '0;
      last_stamp           <= '0;
      last_was_idle        <= 1'b0;
      stamp_seen           <= 1'b0;
      stored_tenths        <= '0;
      stored_thousandths   <= '0;
      out_valid            <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) window_length_clocks <= cfg_wr_data;

      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            stamp_seen    <= 1'b1;
            last_stamp    <= time_stamp;
            last_was_idle <= idle_now;
          end
        end
        ST_ACCUM: begin
          window_count <= window_count + elapsed;
          if (add_idle) idle_count <= idle_count + elapsed;
        end
        ST_CHECK: begin
          if (window_full) begin
            window_count <= '0;
            idle_count   <= '0;
          end
        end
        ST_PREP: begin
          if (win_clocks == '0) begin
            stored_tenths      <= '0;
            stored_thousandths <= '0;
          end else if (busy_clocks >= win_clocks) begin
            // share at or above one: saturate
            stored_tenths      <= TENTHS_W'(SCALE_TENTHS);
            stored_thousandths <= THOU_W'(SCALE_THOU);
          end
        end
        ST_DIV_T: if (div_stat.done) stored_tenths <= TENTHS_W'(div_quotient);
        ST_DIV_K: if (div_stat.done) stored_thousandths <= THOU_W'(div_quotient);
        default: begin
        end
      endcase

      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_beat) begin
      elapsed  <= CNT_BITS'(stamp_diff);
      add_idle <= last_was_idle;
      closed   <= 1'b0;
    end
    if (state == ST_CHECK && window_full) begin
      busy_clocks <= window_count - idle_count;
      win_clocks  <= window_count;
      closed      <= 1'b1;
    end
    if (state == ST_DONE && out_free) begin
      load_tenths      <= stored_tenths;
      load_thousandths <= stored_thousandths;
      load_percent     <= PCT_W'(pct_product >> PCT_SHIFT);
      window_closed    <= closed;
    end
  end

  `CLWM_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready)
  `CLWM_ASSERT_NOW(a_div_done_in_div, div_stat.done, (state == ST_DIV_T) || (state == ST_DIV_K))
  `CLWM_ASSERT_NEXT(a_clear_on_close, (state == ST_CHECK) && window_full,
                    (window_count == '0) && (idle_count == '0))
  `CLWM_ASSERT_NOW(a_load_range, out_valid,
                   (load_tenths <= 10'd1000) && (load_thousandths <= 17'd100000))

endmodule

`default_nettype wire
